/* design/dps_pkg.sv */
// ----------------------------------------------------------------------------
// dps_pkg
// Shared types and constants of the deadline or rate priority scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package dps_pkg;

	// action codes of an input item
	localparam logic [1:0] ACT_LOAD    = 2'd0;
	localparam logic [1:0] ACT_TICK    = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	// fixed field widths
	localparam int unsigned SLOT_W = 4;
	localparam int unsigned KEY_W  = 16;
	localparam int unsigned TIME_W = 20;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// one task slot as stored in the task memory
	typedef struct packed {
		logic [KEY_W-1:0] burst;
		logic [KEY_W-1:0] deadline;
		logic [KEY_W-1:0] period;
	} task_t;

	// one candidate seen by the selection unit
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] rem;
		logic [KEY_W-1:0] burst;
	} cand_t;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_RESTART = 5'b00010,
		ST_SCAN    = 5'b00100,
		ST_UPDATE  = 5'b01000,
		ST_OUT     = 5'b10000
	} state_t;

endpackage

`default_nettype wire

/* design/dps_ram.sv */
// ----------------------------------------------------------------------------
// dps_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dps_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* design/dps_pick.sv */
// ----------------------------------------------------------------------------
// dps_pick
// Shared key comparator: keeps the slot with the smallest key seen so far,
// first one wins on a tie.
// ----------------------------------------------------------------------------
`default_nettype none

module dps_pick #(
	parameter int unsigned IDX_W = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             clear,
	input  wire logic             take,
	input  wire logic [IDX_W-1:0] cand_idx,
	input  wire dps_pkg::cand_t   cand,
	output logic                  found,
	output logic      [IDX_W-1:0] best_idx,
	output dps_pkg::cand_t        best
);
	import dps_pkg::*;

	logic found_q;
	logic [IDX_W-1:0] best_idx_q;
	cand_t best_q;
	logic better;

	// strict compare keeps the lowest slot on equal keys
	assign better = take && (!found_q || (cand.key < best_q.key));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clear) begin
			found_q <= 1'b0;
		end else if (better) begin
			found_q <= 1'b1;
		end
	end

	// best candidate payload
	always_ff @(posedge clk) begin
		if (better) begin
			best_idx_q <= cand_idx;
			best_q     <= cand;
		end
	end

	assign found    = found_q;
	assign best_idx = best_idx_q;
	assign best     = best_q;

endmodule

`default_nettype wire

/* design/deadline_or_rate_priority_scheduler.sv */
// A load or an unused action goes straight to the output state; a restart sweeps
// every slot, and a tick sweeps every slot and then updates the chosen slot.
// Throughput: one item at a time; the input is ready only in the idle state,
// after the slot scan of a restart or tick and once the output register is free.
// Reset clears slot valid bits, work flags, time, policy and the output valid;
// memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// deadline_or_rate_priority_scheduler
// Preemptive unit-tick scheduler, earliest deadline first or rate monotonic.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_or_rate_priority_scheduler #(
	parameter int unsigned MAX_TASKS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        policy_mode,
	// input items
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [3:0]  task_slot,
	input  wire logic [15:0] burst_time,
	input  wire logic [15:0] task_deadline,
	input  wire logic [15:0] task_period,
	// result items
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       ran_task,
	output logic             idle,
	output logic             finished,
	output logic [19:0]      finish_time,
	output logic [19:0]      wait_time,
	output logic             all_done
);
	import dps_pkg::*;

	localparam int unsigned IW = $clog2(MAX_TASKS);
	localparam int unsigned CW = $clog2(MAX_TASKS + 1);
	localparam logic [CW-1:0] CNT_END = CW'(MAX_TASKS);

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic rd_vld_s1;
	logic [IW-1:0] idx_s1;
	logic [MAX_TASKS-1:0] slot_valid_q;
	logic [MAX_TASKS-1:0] work_q;
	logic [CW-1:0] work_cnt_q;
	logic [TIME_W-1:0] time_q;
	logic policy_q;
	logic out_valid_q;

	// pending result
	logic [SLOT_W-1:0] res_ran_q;
	logic res_idle_q, res_fin_q, res_done_q;
	logic [TIME_W-1:0] res_ftime_q, res_wait_q;

	logic in_fire, scan_busy, issue, sweep_done, out_free;
	logic slot_ok;
	logic [IW-1:0] rd_addr;
	task_t task_wr, task_rd;
	logic [KEY_W-1:0] rem_rd, rem_wdata;
	logic rem_we;
	logic [IW-1:0] rem_waddr;
	logic restart_wr, new_work;
	logic pick_take;
	cand_t cand;
	logic found;
	logic [IW-1:0] best_idx;
	cand_t best;
	logic [KEY_W-1:0] new_rem;
	logic fin;
	logic [TIME_W-1:0] time_inc, burst_ext, wait_val;
	logic [CW-1:0] work_cnt_after;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign scan_busy = (state_q == ST_RESTART) || (state_q == ST_SCAN);
	assign issue     = scan_busy && (cnt_q != CNT_END);
	assign sweep_done = scan_busy && (cnt_q == CNT_END) && !rd_vld_s1;
	assign out_free  = !out_valid_q || out_ready;
	assign slot_ok   = 32'(task_slot) < MAX_TASKS;
	assign rd_addr   = cnt_q[IW-1:0];

	// task memory: written by loads, read by the sweeps
	assign task_wr = '{burst: burst_time, deadline: task_deadline, period: task_period};

	dps_ram #(
		.WIDTH ($bits(task_t)),
		.DEPTH (MAX_TASKS)
	) u_task_ram (
		.clk   (clk),
		.we    (in_fire && (action == ACT_LOAD) && slot_ok),
		.waddr (IW'(task_slot)),
		.wdata (task_wr),
		.raddr (rd_addr),
		.rdata (task_rd)
	);

	// remaining work memory: written by the restart sweep and by a tick
	assign restart_wr = (state_q == ST_RESTART) && rd_vld_s1;
	assign new_work   = slot_valid_q[idx_s1] && (task_rd.burst != '0);
	assign rem_we     = restart_wr || ((state_q == ST_UPDATE) && found);
	assign rem_waddr  = (state_q == ST_UPDATE) ? best_idx : idx_s1;
	assign rem_wdata  = (state_q == ST_UPDATE) ? new_rem : task_rd.burst;

	dps_ram #(
		.WIDTH (KEY_W),
		.DEPTH (MAX_TASKS)
	) u_rem_ram (
		.clk   (clk),
		.we    (rem_we),
		.waddr (rem_waddr),
		.wdata (rem_wdata),
		.raddr (rd_addr),
		.rdata (rem_rd)
	);

	// shared comparator over the scanned slots
	assign pick_take = (state_q == ST_SCAN) && rd_vld_s1 && work_q[idx_s1];
	assign cand = '{key:   (policy_q ? task_rd.period : task_rd.deadline),
	                rem:   rem_rd,
	                burst: task_rd.burst};

	dps_pick #(
		.IDX_W (IW)
	) u_pick (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (in_fire),
		.take     (pick_take),
		.cand_idx (idx_s1),
		.cand     (cand),
		.found    (found),
		.best_idx (best_idx),
		.best     (best)
	);

	// tick arithmetic
	assign new_rem   = best.rem - KEY_W'(1);
	assign fin       = found && (new_rem == '0);
	assign time_inc  = (time_q == TIME_MAX) ? time_q : time_q + TIME_W'(1);
	assign burst_ext = TIME_W'(best.burst);
	assign wait_val  = (time_inc > burst_ext) ? (time_inc - burst_ext) : '0;
	assign work_cnt_after = fin ? (work_cnt_q - CW'(1)) : work_cnt_q;

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					case (action)
						ACT_TICK:    state_d = ST_SCAN;
						ACT_RESTART: state_d = ST_RESTART;
						default:     state_d = ST_OUT;
					endcase
				end
			end
			ST_RESTART: begin
				if (sweep_done) state_d = ST_OUT;
			end
			ST_SCAN: begin
				if (sweep_done) state_d = ST_UPDATE;
			end
			ST_UPDATE: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			rd_vld_s1    <= 1'b0;
			slot_valid_q <= '0;
			work_q       <= '0;
			work_cnt_q   <= '0;
			time_q       <= '0;
			policy_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (cfg_valid) begin
				policy_q <= policy_mode;
			end
			if (in_fire) begin
				cnt_q <= '0;
				if ((action == ACT_LOAD) && slot_ok) begin
					slot_valid_q[IW'(task_slot)] <= 1'b1;
				end
				if (action == ACT_RESTART) begin
					work_cnt_q <= '0;
					time_q     <= '0;
				end
			end else if (issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
			// restart sweep rebuilds the work flags and their count
			if (restart_wr) begin
				work_q[idx_s1] <= new_work;
				work_cnt_q     <= work_cnt_q + CW'(new_work);
			end
			// tick advances time and retires the chosen slot when its work runs out
			if (state_q == ST_UPDATE) begin
				time_q <= time_inc;
				if (fin) begin
					work_q[best_idx] <= 1'b0;
					work_cnt_q       <= work_cnt_after;
				end
			end
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// read pipeline index and result payload
	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1 <= rd_addr;
		end
		if (in_fire) begin
			res_ran_q   <= '0;
			res_idle_q  <= 1'b0;
			res_fin_q   <= 1'b0;
			res_ftime_q <= '0;
			res_wait_q  <= '0;
			res_done_q  <= 1'b0;
		end else if (state_q == ST_UPDATE) begin
			res_ran_q   <= found ? SLOT_W'(best_idx) : '0;
			res_idle_q  <= !found;
			res_fin_q   <= fin;
			res_ftime_q <= fin ? time_inc : '0;
			res_wait_q  <= fin ? wait_val : '0;
			res_done_q  <= (work_cnt_after == '0);
		end
		if ((state_q == ST_OUT) && out_free) begin
			ran_task    <= res_ran_q;
			idle        <= res_idle_q;
			finished    <= res_fin_q;
			finish_time <= res_ftime_q;
			wait_time   <= res_wait_q;
			all_done    <= res_done_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
